### src/disjoint_set_union_table_assert.svh
// ----------------------------------------------------------------------------
// Disjoint-set table assertion macros
// Shorthand for the concurrent checks used inside the table's RTL.
// ----------------------------------------------------------------------------
`ifndef DISJOINT_SET_UNION_TABLE_ASSERT_SVH
`define DISJOINT_SET_UNION_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSU_ASSERT_IMP(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("disjoint set table: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSU_ASSERT_NXT(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("disjoint set table: check failed");

`endif

### src/dsu_pkg.sv
// ----------------------------------------------------------------------------
// Disjoint-set table package
// Sizes, beat payload types, table entry format and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package dsu_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int IDX_W        = 10;
	localparam int CNT_W        = 11;
	localparam int REG_ADDR_W   = 3;

	localparam logic [REG_ADDR_W-3:0] REG_ELEMENT_COUNT = 1'd0;
	localparam logic [CNT_W-1:0]      COUNT_RESET       = CNT_W'(MAX_ELEMENTS);

	localparam logic REQ_QUERY = 1'b0;
	localparam logic REQ_UNITE = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] second_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] first_root;
		logic [IDX_W-1:0] second_root;
		logic             already_same;
		logic             merged;
		logic [CNT_W-1:0] set_size;
		logic             bad_index;
	} rsp_t;

	// A root holds its set size in val; any other entry holds its parent link.
	typedef struct packed {
		logic             root;
		logic [CNT_W-1:0] val;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] raddr;
		entry_t           wdata;
	} tbl_req_t;

endpackage

`default_nettype wire

### src/dsu_table.sv
// ----------------------------------------------------------------------------
// Disjoint-set table memory
// One write port and one registered read port over all table entries.
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_table (
	input  wire logic              clk,
	input  wire dsu_pkg::tbl_req_t tbl,
	output dsu_pkg::entry_t        rd
);
	import dsu_pkg::*;

	entry_t mem [MAX_ELEMENTS];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (tbl.we) begin
			mem[tbl.waddr] <= tbl.wdata;
		end
		rd_q <= mem[tbl.raddr];
	end

	assign rd = rd_q;

endmodule

`default_nettype wire

### src/dsu_ctrl.sv
// ----------------------------------------------------------------------------
// Disjoint-set table sequencer
// Walks both parent chains, compresses them, and links roots on a unite.
// ----------------------------------------------------------------------------
`default_nettype none
`include "disjoint_set_union_table_assert.svh"

module dsu_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	input  wire dsu_pkg::req_t             req,
	input  wire logic [dsu_pkg::CNT_W-1:0] count,
	input  wire logic                      res_ready,
	input  wire dsu_pkg::entry_t           rd,
	output logic                           idle,
	output dsu_pkg::tbl_req_t              tbl,
	output logic                           res_valid,
	output dsu_pkg::rsp_t                  res
);
	import dsu_pkg::*;

	typedef enum logic [8:0] {
		ST_CLEAR       = 9'b000000001,
		ST_IDLE        = 9'b000000010,
		ST_FIND_A      = 9'b000000100,
		ST_COMP_A      = 9'b000001000,
		ST_FIND_B      = 9'b000010000,
		ST_COMP_B      = 9'b000100000,
		ST_UNITE_ROOT  = 9'b001000000,
		ST_UNITE_LINK  = 9'b010000000,
		ST_DONE        = 9'b100000000
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] clr_q;
	logic             type_q;
	logic [IDX_W-1:0] a_q;
	logic [IDX_W-1:0] b_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] ra_q;
	logic [IDX_W-1:0] rb_q;
	logic [CNT_W-1:0] size_a_q;
	logic [CNT_W-1:0] size_b_q;
	logic             a_small_q;
	logic             same_q;
	logic             merged_q;
	logic             bad_q;

	logic [IDX_W-1:0] link;
	logic [CNT_W-1:0] cnt_eff;
	logic             bad;
	logic [CNT_W-1:0] sum;
	logic [IDX_W-1:0] big;
	logic [IDX_W-1:0] small_root;

	assign link       = rd.val[IDX_W-1:0];
	assign cnt_eff    = (count > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : count;
	assign bad        = ({1'b0, req.first_index} >= cnt_eff)
		|| ({1'b0, req.second_index} >= cnt_eff);
	assign sum        = size_a_q + size_b_q;
	assign big        = a_small_q ? rb_q : ra_q;
	assign small_root = a_small_q ? ra_q : rb_q;
	assign idle       = (state_q == ST_IDLE);
	assign res_valid  = (state_q == ST_DONE);

	always_comb begin
		tbl.we    = 1'b0;
		tbl.waddr = cur_q;
		tbl.raddr = cur_q;
		tbl.wdata = '{root: 1'b0, val: CNT_W'(ra_q)};
		case (state_q)
			ST_CLEAR: begin
				tbl.we    = 1'b1;
				tbl.waddr = clr_q;
				tbl.wdata = '{root: 1'b1, val: CNT_W'(1)};
			end
			ST_IDLE: begin
				tbl.raddr = req.first_index;
			end
			ST_FIND_A: begin
				tbl.raddr = rd.root ? a_q : link;
			end
			ST_FIND_B: begin
				tbl.raddr = rd.root ? b_q : link;
			end
			ST_COMP_A: begin
				if (rd.root) begin
					tbl.raddr = b_q;
				end else begin
					tbl.we    = 1'b1;
					tbl.raddr = link;
					tbl.wdata = '{root: 1'b0, val: CNT_W'(ra_q)};
				end
			end
			ST_COMP_B: begin
				if (!rd.root) begin
					tbl.we    = 1'b1;
					tbl.raddr = link;
					tbl.wdata = '{root: 1'b0, val: CNT_W'(rb_q)};
				end
			end
			ST_UNITE_ROOT: begin
				tbl.we    = 1'b1;
				tbl.waddr = big;
				tbl.wdata = '{root: 1'b1, val: sum};
			end
			ST_UNITE_LINK: begin
				tbl.we    = 1'b1;
				tbl.waddr = small_root;
				tbl.wdata = '{root: 1'b0, val: CNT_W'(big)};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(MAX_ELEMENTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= bad ? ST_DONE : ST_FIND_A;
					end
				end
				ST_FIND_A: begin
					if (rd.root) begin
						state_q <= ST_COMP_A;
					end
				end
				ST_COMP_A: begin
					if (rd.root) begin
						state_q <= ST_FIND_B;
					end
				end
				ST_FIND_B: begin
					if (rd.root) begin
						state_q <= ST_COMP_B;
					end
				end
				ST_COMP_B: begin
					if (rd.root) begin
						state_q <= (type_q == REQ_UNITE && ra_q != rb_q) ? ST_UNITE_ROOT : ST_DONE;
					end
				end
				ST_UNITE_ROOT: begin
					state_q <= ST_UNITE_LINK;
				end
				ST_UNITE_LINK: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				type_q <= req.req_type;
				a_q    <= req.first_index;
				b_q    <= req.second_index;
				cur_q  <= req.first_index;
				bad_q  <= bad;
			end
			ST_FIND_A: begin
				if (rd.root) begin
					ra_q     <= cur_q;
					size_a_q <= rd.val;
					cur_q    <= a_q;
				end else begin
					cur_q <= link;
				end
			end
			ST_COMP_A: begin
				cur_q <= rd.root ? b_q : link;
			end
			ST_FIND_B: begin
				if (rd.root) begin
					rb_q     <= cur_q;
					size_b_q <= rd.val;
					cur_q    <= b_q;
				end else begin
					cur_q <= link;
				end
			end
			ST_COMP_B: begin
				if (rd.root) begin
					same_q    <= (ra_q == rb_q);
					merged_q  <= (type_q == REQ_UNITE && ra_q != rb_q);
					a_small_q <= (size_a_q < size_b_q);
				end else begin
					cur_q <= link;
				end
			end
			ST_UNITE_LINK: begin
				size_a_q <= sum;
				if (a_small_q) begin
					ra_q <= rb_q;
				end else begin
					rb_q <= ra_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (bad_q) begin
			res = '{first_root: '0, second_root: '0, already_same: 1'b0, merged: 1'b0,
				set_size: '0, bad_index: 1'b1};
		end else begin
			res = '{first_root: ra_q, second_root: rb_q, already_same: same_q,
				merged: merged_q, set_size: size_a_q, bad_index: 1'b0};
		end
	end

	`DSU_ASSERT_IMP(a_comp_spares_root, clk, arst_n, tbl.we && (state_q == ST_COMP_A), tbl.waddr != ra_q)
	`DSU_ASSERT_IMP(a_merge_one_root, clk, arst_n, res_valid && res.merged, res.first_root == res.second_root)
	`DSU_ASSERT_IMP(a_size_nonzero, clk, arst_n, res_valid && !res.bad_index, res.set_size != '0)
	`DSU_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, idle && req_valid, state_q != ST_IDLE)

endmodule

`default_nettype wire

### src/disjoint_set_union_table.sv
// ----------------------------------------------------------------------------
// Disjoint-set table, top level
// Union by size with path compression over a one-read, one-write table memory.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid/req_stall    req_data (dsu_pkg::req_t)
//   rsp       out        rsp_valid/rsp_stall    rsp_data (dsu_pkg::rsp_t)
//   config    in         APB (psel/penable)     element_count at byte 0
//
// After reset every table entry is swept to a singleton; req_stall stays high
// during the sweep, while register writes are taken as usual.
// A request walks each parent chain twice, once to find the root and once to
// compress the path, and a merge adds a root write and a link write. The table's
// single read port follows one link per cycle; a bad index skips the walks.
// The result waits in an output register, so a stalled rsp beat holds the
// sequencer only at the end of the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module disjoint_set_union_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [dsu_pkg::REG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic      [31:0]                    prdata,
	output logic                                pready,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire dsu_pkg::req_t                  req_data,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output dsu_pkg::rsp_t                       rsp_data
);
	import dsu_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic     idle;
	logic     res_valid;
	logic     res_ready;
	rsp_t     res;
	tbl_req_t tbl;
	entry_t   rd;
	logic     reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[REG_ADDR_W-1:2] == REG_ELEMENT_COUNT);
	assign prdata  = reg_hit ? {{(32 - CNT_W){1'b0}}, count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign req_stall = !idle;

	dsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req_data),
		.count     (count_q),
		.res_ready (res_ready),
		.rd        (rd),
		.idle      (idle),
		.tbl       (tbl),
		.res_valid (res_valid),
		.res       (res)
	);

	dsu_table u_table (
		.clk (clk),
		.tbl (tbl),
		.rd  (rd)
	);

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// Disjoint-set table testbench
// Drives union and query requests through the valid/stall channels. A
// software copy of the union-find table predicts every response beat,
// including the root, size and bad-index fields. Directed requests come first,
// then random phases that vary the element count and the idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class union_find_tracker;
	bit            is_root [dsu_pkg::MAX_ELEMENTS];
	int unsigned   link [dsu_pkg::MAX_ELEMENTS];
	int unsigned   set_sizes [dsu_pkg::MAX_ELEMENTS];
	int unsigned   element_count;
	dsu_pkg::rsp_t pending_replies [$];
	int            mismatches;

	function new();
		for (int i = 0; i < dsu_pkg::MAX_ELEMENTS; i++) begin
			is_root[i] = 1'b1;
			link[i] = i;
			set_sizes[i] = 1;
		end
		element_count = dsu_pkg::COUNT_RESET;
		mismatches = 0;
	endfunction

	function void record(string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s", $time, msg);
		end
	endfunction

	// Finds the root and then points every element of the walked path at it.
	function int unsigned find_root(int unsigned x);
		int unsigned r;
		int unsigned cur;
		int unsigned nxt;
		int unsigned steps;
		r = x;
		steps = 0;
		while (!is_root[r] && steps < dsu_pkg::MAX_ELEMENTS) begin
			r = link[r] % dsu_pkg::MAX_ELEMENTS;
			steps++;
		end
		cur = x;
		steps = 0;
		while (cur != r && !is_root[cur] && steps < dsu_pkg::MAX_ELEMENTS) begin
			nxt = link[cur] % dsu_pkg::MAX_ELEMENTS;
			link[cur] = r;
			cur = nxt;
			steps++;
		end
		return r;
	endfunction

	function void note_request(dsu_pkg::req_t r);
		int unsigned   lim;
		int unsigned   ra;
		int unsigned   rb;
		int unsigned   sz;
		bit            same;
		dsu_pkg::rsp_t want;
		want = '0;
		lim = (element_count < dsu_pkg::MAX_ELEMENTS) ? element_count : dsu_pkg::MAX_ELEMENTS;
		if (r.first_index >= lim || r.second_index >= lim) begin
			want.bad_index = 1'b1;
			pending_replies = {pending_replies, want};
			return;
		end
		ra = find_root(r.first_index);
		rb = find_root(r.second_index);
		same = (ra == rb);
		if (r.req_type == dsu_pkg::REQ_UNITE && !same) begin
			if (set_sizes[ra] < set_sizes[rb]) begin
				set_sizes[rb] += set_sizes[ra];
				is_root[ra] = 1'b0;
				link[ra] = rb;
				ra = rb;
			end else begin
				set_sizes[ra] += set_sizes[rb];
				is_root[rb] = 1'b0;
				link[rb] = ra;
				rb = ra;
			end
			want.merged = 1'b1;
		end
		sz = set_sizes[ra];
		if (sz > (1 << dsu_pkg::CNT_W) - 1) begin
			sz = (1 << dsu_pkg::CNT_W) - 1;
		end
		want.first_root = ra[dsu_pkg::IDX_W-1:0];
		want.second_root = rb[dsu_pkg::IDX_W-1:0];
		want.already_same = same;
		want.set_size = sz[dsu_pkg::CNT_W-1:0];
		pending_replies = {pending_replies, want};
	endfunction

	function void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			record($sformatf("%s: expected %0d, got %0d", field, want, got));
		end
	endfunction

	function void check_reply(dsu_pkg::rsp_t got);
		dsu_pkg::rsp_t want;
		if (pending_replies.size() == 0) begin
			record($sformatf("response beat %h arrived with no request waiting", got));
			return;
		end
		want = pending_replies.pop_front();
		compare_field("first_root", 32'(want.first_root), 32'(got.first_root));
		compare_field("second_root", 32'(want.second_root), 32'(got.second_root));
		compare_field("already_same", 32'(want.already_same), 32'(got.already_same));
		compare_field("merged", 32'(want.merged), 32'(got.merged));
		compare_field("set_size", 32'(want.set_size), 32'(got.set_size));
		compare_field("bad_index", 32'(want.bad_index), 32'(got.bad_index));
	endfunction
endclass

module tb;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} pace_t;

	localparam int STALL_LIMIT   = 8000;
	localparam int SETTLE_CYCLES = 60;
	localparam int PHASES        = 11;

	localparam logic [dsu_pkg::REG_ADDR_W-1:0] COUNT_ADDR = {dsu_pkg::REG_ELEMENT_COUNT, 2'b00};
	localparam logic [dsu_pkg::REG_ADDR_W-1:0] SPARE_ADDR = dsu_pkg::REG_ADDR_W'(4);

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [dsu_pkg::REG_ADDR_W-1:0] paddr = '0;
	logic [31:0]                    pwdata = '0;
	logic [31:0]                    prdata;
	logic                           pready;
	logic                           req_valid = 1'b0;
	logic                           req_stall;
	dsu_pkg::req_t                  req_data = '0;
	logic                           rsp_valid;
	logic                           rsp_stall = 1'b0;
	dsu_pkg::rsp_t                  rsp_data;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int idle_cycles = 0;

	int unsigned phase_counts [PHASES] = '{1024, 300, 2047, 64, 1025, 16, 2, 1024, 700, 0, 1024};
	int          phase_items [PHASES]  = '{200, 200, 200, 200, 200, 60, 60, 200, 200, 20, 260};

	union_find_tracker tracker = new();

	disjoint_set_union_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				tracker.note_request(req_data);
			end
			if (rsp_valid && !rsp_stall) begin
				tracker.check_reply(rsp_data);
			end
		end
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable && pready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic set_pace(pace_t pace);
		case (pace)
			IDLE_NONE: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 56;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				stall_pct = 56;
			end
			default: begin
				send_idle_pct = 19;
				stall_pct = 19;
			end
		endcase
	endtask

	task automatic push_request(dsu_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic issue(logic kind, int unsigned a, int unsigned b);
		dsu_pkg::req_t r;
		r.req_type = kind;
		r.first_index = a[dsu_pkg::IDX_W-1:0];
		r.second_index = b[dsu_pkg::IDX_W-1:0];
		push_request(r);
	endtask

	task automatic finish_phase();
		@(negedge clk);
		req_valid <= 1'b0;
		while (tracker.pending_replies.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic apb_write(logic [dsu_pkg::REG_ADDR_W-1:0] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(logic [dsu_pkg::REG_ADDR_W-1:0] addr, output logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		value = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_element_count(logic [31:0] value);
		logic [31:0] readback;
		apb_write(COUNT_ADDR, value);
		tracker.element_count = value[dsu_pkg::CNT_W-1:0];
		apb_read(COUNT_ADDR, readback);
		if (readback !== 32'(value[dsu_pkg::CNT_W-1:0])) begin
			tracker.record($sformatf("element_count readback: expected %0d, got %0d",
				value[dsu_pkg::CNT_W-1:0], readback));
		end
	endtask

	// Mostly valid indices, with a crowded low window so that sets collide often.
	function automatic int unsigned pick_index(int unsigned lim);
		if (lim == 0 || $urandom_range(99) < 8) begin
			return $urandom_range(dsu_pkg::MAX_ELEMENTS - 1);
		end
		if ($urandom_range(99) < 30) begin
			return $urandom_range(lim < 32 ? lim - 1 : 31);
		end
		return $urandom_range(lim - 1);
	endfunction

	task automatic random_phase(int unsigned count_value, int items, pace_t pace);
		int unsigned lim;
		set_element_count(count_value);
		lim = count_value[dsu_pkg::CNT_W-1:0];
		if (lim > dsu_pkg::MAX_ELEMENTS) begin
			lim = dsu_pkg::MAX_ELEMENTS;
		end
		set_pace(pace);
		for (int i = 0; i < items; i++) begin
			issue(($urandom_range(99) < 60) ? dsu_pkg::REQ_UNITE : dsu_pkg::REQ_QUERY,
				pick_index(lim), pick_index(lim));
		end
		finish_phase();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_pace(IDLE_NONE);
		set_element_count(32'(dsu_pkg::COUNT_RESET));
		issue(dsu_pkg::REQ_QUERY, 0, 0);
		issue(dsu_pkg::REQ_QUERY, 1023, 1023);
		issue(dsu_pkg::REQ_UNITE, 0, 1023);
		issue(dsu_pkg::REQ_UNITE, 1023, 0);
		issue(dsu_pkg::REQ_UNITE, 5, 6);
		issue(dsu_pkg::REQ_UNITE, 7, 5);
		issue(dsu_pkg::REQ_UNITE, 5, 0);
		issue(dsu_pkg::REQ_QUERY, 1023, 6);
		issue(dsu_pkg::REQ_QUERY, 1023, 7);
		issue(dsu_pkg::REQ_UNITE, 1000, 3);
		issue(dsu_pkg::REQ_UNITE, 682, 341);
		issue(dsu_pkg::REQ_QUERY, 682, 5);
		issue(dsu_pkg::REQ_UNITE, 512, 511);
		finish_phase();

		// Upper data bits are dropped by the register, which leaves a count of 16.
		set_pace(IDLE_BOTH);
		set_element_count(32'hFFFF_F810);
		issue(dsu_pkg::REQ_QUERY, 3, 3);
		issue(dsu_pkg::REQ_QUERY, 16, 0);
		issue(dsu_pkg::REQ_QUERY, 0, 16);
		issue(dsu_pkg::REQ_UNITE, 15, 1023);
		issue(dsu_pkg::REQ_UNITE, 15, 14);
		issue(dsu_pkg::REQ_UNITE, 3, 15);
		finish_phase();

		apb_write(SPARE_ADDR, 32'd5);
		set_element_count(32'd0);
		issue(dsu_pkg::REQ_QUERY, 0, 0);
		issue(dsu_pkg::REQ_UNITE, 1023, 1023);
		finish_phase();

		set_element_count(32'd2047);
		issue(dsu_pkg::REQ_UNITE, 1023, 1);
		issue(dsu_pkg::REQ_QUERY, 1023, 512);
		finish_phase();

		set_element_count(32'd1);
		issue(dsu_pkg::REQ_QUERY, 0, 0);
		issue(dsu_pkg::REQ_UNITE, 0, 1);
		issue(dsu_pkg::REQ_UNITE, 0, 0);
		finish_phase();

		for (int p = 0; p < PHASES; p++) begin
			random_phase(phase_counts[p], phase_items[p], pace_t'(p % 4));
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
